// ===== rtl/mcpu_pkg.sv =====
`timescale 1ns / 1ps

package mcpu_pkg;

   localparam int RAM_WORDS   = 16;
   localparam int RAM_AW      = $clog2(RAM_WORDS);
   localparam int DATA_W      = 8;
   localparam int MICRO_STEPS = 5;
   localparam int STEP_W      = 3;
   localparam int CW_W        = 16;
   localparam int OPC_W       = 4;

   typedef enum logic [1:0] {
      ACT_WRITE   = 2'd0,
      ACT_RESTART = 2'd1,
      ACT_TICK    = 2'd2,
      ACT_NONE    = 2'd3
   } action_type;

   // control word bits
   localparam logic [CW_W-1:0] C_HALT   = 16'h8000;
   localparam logic [CW_W-1:0] C_MARIN  = 16'h4000;
   localparam logic [CW_W-1:0] C_RAMIN  = 16'h2000;
   localparam logic [CW_W-1:0] C_RAMOUT = 16'h1000;
   localparam logic [CW_W-1:0] C_IROUT  = 16'h0800;
   localparam logic [CW_W-1:0] C_IRIN   = 16'h0400;
   localparam logic [CW_W-1:0] C_AIN    = 16'h0200;
   localparam logic [CW_W-1:0] C_AOUT   = 16'h0100;
   localparam logic [CW_W-1:0] C_ALUOUT = 16'h0080;
   localparam logic [CW_W-1:0] C_NEGB   = 16'h0040;
   localparam logic [CW_W-1:0] C_BIN    = 16'h0020;
   localparam logic [CW_W-1:0] C_OUTIN  = 16'h0010;
   localparam logic [CW_W-1:0] C_PCINC  = 16'h0008;
   localparam logic [CW_W-1:0] C_PCOUT  = 16'h0004;
   localparam logic [CW_W-1:0] C_JUMP   = 16'h0002;

   localparam logic [CW_W-1:0] FETCH0 = C_MARIN | C_PCOUT;
   localparam logic [CW_W-1:0] FETCH1 = C_RAMOUT | C_IRIN | C_PCINC;

   localparam logic [OPC_W-1:0] OP_LDA = 4'd1;
   localparam logic [OPC_W-1:0] OP_ADD = 4'd2;
   localparam logic [OPC_W-1:0] OP_SUB = 4'd3;
   localparam logic [OPC_W-1:0] OP_STA = 4'd4;
   localparam logic [OPC_W-1:0] OP_LDI = 4'd5;
   localparam logic [OPC_W-1:0] OP_JMP = 4'd6;
   localparam logic [OPC_W-1:0] OP_OUT = 4'd14;
   localparam logic [OPC_W-1:0] OP_HLT = 4'd15;

   typedef struct packed {
      logic                 en;
      logic [RAM_AW-1:0]    addr;
      logic [DATA_W-1:0]    data;
   } ram_wr_type;

   typedef struct packed {
      logic [DATA_W-1:0]    display;
      logic                 display_written;
      logic                 halted;
      logic [DATA_W-1:0]    accumulator;
      logic [RAM_AW-1:0]    program_counter;
      logic [STEP_W-1:0]    micro_step;
      logic [DATA_W-1:0]    bus_value;
   } result_type;

   function automatic logic [CW_W-1:0] microcode(input logic [OPC_W-1:0] opcode,
                                                 input logic [STEP_W-1:0] step);
      logic [CW_W-1:0] cw;
      cw = '0;
      case (step)
         3'd0: cw = FETCH0;
         3'd1: cw = FETCH1;
         3'd2: begin
            case (opcode)
               OP_LDA:  cw = C_IROUT | C_MARIN;
               OP_ADD:  cw = C_IROUT | C_MARIN;
               OP_SUB:  cw = C_IROUT | C_MARIN;
               OP_STA:  cw = C_IROUT | C_MARIN;
               OP_LDI:  cw = C_IROUT | C_AIN;
               OP_JMP:  cw = C_IROUT | C_JUMP;
               OP_OUT:  cw = C_AOUT | C_OUTIN;
               OP_HLT:  cw = C_HALT;
               default: cw = '0;
            endcase
         end
         3'd3: begin
            case (opcode)
               OP_LDA:  cw = C_RAMOUT | C_AIN;
               OP_ADD:  cw = C_RAMOUT | C_BIN;
               OP_SUB:  cw = C_RAMOUT | C_BIN;
               OP_STA:  cw = C_AOUT | C_RAMIN;
               default: cw = '0;
            endcase
         end
         3'd4: begin
            case (opcode)
               OP_ADD:  cw = C_ALUOUT | C_AIN;
               OP_SUB:  cw = C_ALUOUT | C_AIN | C_NEGB;
               default: cw = '0;
            endcase
         end
         default: cw = '0;
      endcase
      return cw;
   endfunction

endpackage

// ===== rtl/mcpu_ram.sv =====
`timescale 1ns / 1ps

module mcpu_ram (
   input  logic                         clock,
   input  mcpu_pkg::ram_wr_type         wr,
   input  logic [mcpu_pkg::RAM_AW-1:0]  rd_addr,
   output logic [mcpu_pkg::DATA_W-1:0]  rd_data
);
   import mcpu_pkg::*;

   logic [DATA_W-1:0] mem [RAM_WORDS];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // write-first: a write to the address being read shows up next cycle
   always_ff @(posedge clock) begin
      if (wr.en && (wr.addr == rd_addr)) begin
         rd_data_ff <= wr.data;
      end else begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/mcpu_exec.sv =====
`timescale 1ns / 1ps

module mcpu_exec (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         accept,
   input  mcpu_pkg::action_type         action,
   input  logic [mcpu_pkg::RAM_AW-1:0]  address,
   input  logic [mcpu_pkg::DATA_W-1:0]  write_data,
   input  logic [mcpu_pkg::DATA_W-1:0]  rd_data,
   output mcpu_pkg::ram_wr_type         ram_wr,
   output logic [mcpu_pkg::RAM_AW-1:0]  rd_addr,
   output mcpu_pkg::result_type         result
);
   import mcpu_pkg::*;

   logic [DATA_W-1:0] acc_ff,  acc_in;
   logic [DATA_W-1:0] b_ff,    b_in;
   logic [RAM_AW-1:0] mar_ff,  mar_in;
   logic [DATA_W-1:0] ir_ff,   ir_in;
   logic [RAM_AW-1:0] pc_ff,   pc_in;
   logic [DATA_W-1:0] bus_ff,  bus_in;
   logic [DATA_W-1:0] out_ff,  out_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              halt_ff, halt_in;

   logic [CW_W-1:0]   cw;
   logic              ticked;
   logic              wrote_out;

   assign cw = microcode(ir_ff[DATA_W-1 -: OPC_W], step_ff);

   always_comb begin
      acc_in    = acc_ff;
      b_in      = b_ff;
      mar_in    = mar_ff;
      ir_in     = ir_ff;
      pc_in     = pc_ff;
      bus_in    = bus_ff;
      out_in    = out_ff;
      step_in   = step_ff;
      halt_in   = halt_ff;
      ticked    = 1'b0;
      wrote_out = 1'b0;
      ram_wr    = '0;

      if (accept) begin
         case (action)
            ACT_WRITE: begin
               ram_wr.en   = 1'b1;
               ram_wr.addr = address;
               ram_wr.data = write_data;
            end
            ACT_RESTART: begin
               acc_in  = '0;
               b_in    = '0;
               mar_in  = '0;
               ir_in   = '0;
               pc_in   = '0;
               bus_in  = '0;
               out_in  = '0;
               step_in = '0;
               halt_in = 1'b0;
            end
            ACT_TICK: begin
               if (!halt_ff) begin
                  ticked = 1'b1;
                  // signals act in the order listed below, each on the bus left so far
                  if ((cw & C_HALT) != '0)  halt_in = 1'b1;
                  if ((cw & C_IROUT) != '0) bus_in = {{(DATA_W-RAM_AW){1'b0}},
                                                      ir_ff[RAM_AW-1:0]};
                  if ((cw & C_PCOUT) != '0) bus_in = {{(DATA_W-RAM_AW){1'b0}}, pc_ff};
                  if ((cw & C_MARIN) != '0) mar_in = bus_in[RAM_AW-1:0];
                  if ((cw & C_AOUT) != '0)  bus_in = acc_ff;
                  if ((cw & C_RAMIN) != '0) begin
                     ram_wr.en   = 1'b1;
                     ram_wr.addr = mar_in;
                     ram_wr.data = bus_in;
                  end
                  // read data is the byte at the MAR held before this tick; no
                  // control word loads the MAR and reads RAM together
                  if ((cw & C_RAMOUT) != '0) bus_in = rd_data;
                  if ((cw & C_IRIN) != '0)   ir_in  = bus_in;
                  if ((cw & C_NEGB) != '0)   b_in   = DATA_W'(~b_ff + 1'b1);
                  if ((cw & C_ALUOUT) != '0) bus_in = DATA_W'(acc_ff + b_in);
                  if ((cw & C_AIN) != '0)    acc_in = bus_in;
                  if ((cw & C_BIN) != '0)    b_in   = bus_in;
                  if ((cw & C_OUTIN) != '0) begin
                     out_in    = bus_in;
                     wrote_out = 1'b1;
                  end
                  if ((cw & C_PCINC) != '0)  pc_in  = RAM_AW'(pc_ff + 1'b1);
                  if ((cw & C_JUMP) != '0)   pc_in  = bus_in[RAM_AW-1:0];
                  step_in = (step_ff == STEP_W'(MICRO_STEPS - 1)) ? '0
                                                                  : STEP_W'(step_ff + 1'b1);
               end
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff  <= '0;
         b_ff    <= '0;
         mar_ff  <= '0;
         ir_ff   <= '0;
         pc_ff   <= '0;
         bus_ff  <= '0;
         out_ff  <= '0;
         step_ff <= '0;
         halt_ff <= 1'b0;
      end else begin
         acc_ff  <= acc_in;
         b_ff    <= b_in;
         mar_ff  <= mar_in;
         ir_ff   <= ir_in;
         pc_ff   <= pc_in;
         bus_ff  <= bus_in;
         out_ff  <= out_in;
         step_ff <= step_in;
         halt_ff <= halt_in;
      end
   end

   // keep the RAM output pointed at the MAR as it will stand next cycle
   assign rd_addr = mar_in;

   always_comb begin
      result.display         = out_in;
      result.display_written = wrote_out;
      result.halted          = halt_in;
      result.accumulator     = acc_in;
      result.program_counter = pc_in;
      result.micro_step      = ticked ? step_ff : '0;
      result.bus_value       = bus_in;
   end

   a_step_range: assert property (@(posedge clock) disable iff (reset)
      step_ff < STEP_W'(MICRO_STEPS))
      else $error("microstep counter out of range");

   a_halt_sticky: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && !(accept && action == ACT_RESTART)) |=> halt_ff)
      else $error("halt cleared without restart");

   a_halt_frozen: assert property (@(posedge clock) disable iff (reset)
      (halt_ff && accept && action == ACT_TICK)
         |=> ($stable(pc_ff) && $stable(acc_ff) && $stable(bus_ff) && $stable(step_ff)))
      else $error("tick changed state while halted");

endmodule

// ===== rtl/mcpu_out_q.sv =====
`timescale 1ns / 1ps

module mcpu_out_q (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   output logic                  in_ready,
   input  mcpu_pkg::result_type  in_data,
   output logic                  out_valid,
   input  logic                  out_ready,
   output mcpu_pkg::result_type  out_data
);
   import mcpu_pkg::*;

   result_type  slot_ff [2];
   logic        wr_ptr_ff, wr_ptr_in;
   logic        rd_ptr_ff, rd_ptr_in;
   logic [1:0]  count_ff,  count_in;
   logic        push, pop;

   assign in_ready  = (count_ff != 2'd2);
   assign out_valid = (count_ff != 2'd0);
   assign out_data  = slot_ff[rd_ptr_ff];
   assign push      = in_valid && in_ready;
   assign pop       = out_valid && out_ready;

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = 2'(count_ff + 1'b1);
      end else if (pop && !push) begin
         count_in = 2'(count_ff - 1'b1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      count_ff <= 2'd2)
      else $error("result queue overflow");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == 2'($past(count_ff) + 1'b1)))
      else $error("result queue lost a push");

   a_ptr_gap: assert property (@(posedge clock) disable iff (reset)
      (count_ff == 2'd1) |-> (wr_ptr_ff != rd_ptr_ff))
      else $error("result queue pointers out of step");

endmodule

// ===== rtl/microcoded_8bit_cpu_core.sv =====
`timescale 1ns / 1ps

// SAP-1 style 8-bit accumulator CPU with 16 bytes of RAM and a fixed microcode ROM
// for eight opcodes. Each request transaction is a RAM write, a restart (clears all
// registers, keeps RAM) or one clock microstep; every request gives exactly one
// response with the register view after it. One request is taken per clock while
// the response queue has room, and its response is registered into that queue.
// The RAM is a synchronous memory whose read port always tracks the next MAR
// value (with write forwarding), so a microstep that drives RAM onto the bus finds
// the byte already registered and ticks run back to back. A two-entry response
// queue lets requests keep flowing while a response waits to be taken. Reading a
// RAM byte never written returns an undefined value.
module microcoded_8bit_cpu_core (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,   // action
   input  logic [15:0] req_tdata,   // address[3:0], write_data[11:4], zero pad
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata    // display[7:0], display_written[8], halted[9],
                                    // accumulator[17:10], program_counter[21:18],
                                    // micro_step[24:22], bus_value[32:25], zero pad
);
   import mcpu_pkg::*;

   logic              accept;
   ram_wr_type        ram_wr;
   logic [RAM_AW-1:0] rd_addr;
   logic [DATA_W-1:0] rd_data;
   result_type        exec_result;
   result_type        q_result;

   assign accept = req_tvalid && req_tready;

   mcpu_ram u_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   mcpu_exec u_exec (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .action     (action_type'(req_tuser)),
      .address    (req_tdata[RAM_AW-1:0]),
      .write_data (req_tdata[RAM_AW +: DATA_W]),
      .rd_data    (rd_data),
      .ram_wr     (ram_wr),
      .rd_addr    (rd_addr),
      .result     (exec_result)
   );

   mcpu_out_q u_out_q (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (accept),
      .in_ready  (req_tready),
      .in_data   (exec_result),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_data  (q_result)
   );

   assign rsp_tdata = {7'd0,
                       q_result.bus_value,
                       q_result.micro_step,
                       q_result.program_counter,
                       q_result.accumulator,
                       q_result.halted,
                       q_result.display_written,
                       q_result.display};

endmodule
